// File: rtl/cbcs_pkg.sv
package cbcs_pkg;

  // machine cycle commands
  typedef enum logic [2:0] {
    CMD_NONE       = 3'd0,
    CMD_FETCH      = 3'd1,
    CMD_HALT_FETCH = 3'd2,
    CMD_INT_ACK    = 3'd3,
    CMD_MEM_READ   = 3'd4,
    CMD_MEM_WRITE  = 3'd5,
    CMD_IO_READ    = 3'd6,
    CMD_IO_WRITE   = 3'd7
  } cmd_t;

  // bit positions in the strobe vector
  localparam int unsigned S_MREQ = 0;
  localparam int unsigned S_RD   = 1;
  localparam int unsigned S_WR   = 2;
  localparam int unsigned S_IORQ = 3;
  localparam int unsigned S_M1   = 4;
  localparam int unsigned S_RFSH = 5;

  localparam logic [5:0] ALL_STROBES   = 6'b11_1111;
  localparam logic [7:0] RFSH_KEEP_MSK = 8'b1000_0000;
  localparam logic [7:0] RFSH_WRAP_MSK = 8'b0111_1111;
  localparam logic [7:0] BYTE_ZERO     = 8'h00;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [15:0] address;
    logic [7:0]  write_data;
    logic [7:0]  refresh_page;
    logic        wait_line;
    logic [7:0]  bus_data_in;
  } in_item_t;

  typedef struct packed {
    logic [15:0] addr_out;
    logic [7:0]  data_out;
    logic        data_drive;
    logic        mreq_line;
    logic        rd_line;
    logic        wr_line;
    logic        iorq_line;
    logic        m1_line;
    logic        rfsh_line;
    logic [7:0]  read_byte;
    logic        cycle_done;
    logic        busy_res;
  } out_item_t;

  // sequencer state carried between the step logic and the top level
  typedef struct packed {
    logic        half_phase;
    logic [3:0]  t_step;
    cmd_t        active_cmd;
    logic [15:0] addr_hold;
    logic [7:0]  data_hold;
    logic        drive_flag;
    logic [5:0]  strobe_bits;
    logic [7:0]  captured_byte;
    logic [7:0]  refresh_count;
  } seq_state_t;

  // final half tick of each command
  function automatic logic [3:0] last_step(cmd_t c);
    case (c)
      CMD_FETCH:      return 4'd7;
      CMD_HALT_FETCH: return 4'd7;
      CMD_INT_ACK:    return 4'd11;
      CMD_MEM_READ:   return 4'd5;
      CMD_MEM_WRITE:  return 4'd5;
      CMD_IO_READ:    return 4'd7;
      CMD_IO_WRITE:   return 4'd7;
      default:        return 4'd0;
    endcase
  endfunction

  // half tick on which WAIT is sampled, zero for never
  function automatic logic [3:0] check_step(cmd_t c);
    case (c)
      CMD_FETCH:     return 4'd3;
      CMD_INT_ACK:   return 4'd7;
      CMD_MEM_READ:  return 4'd3;
      CMD_MEM_WRITE: return 4'd3;
      CMD_IO_READ:   return 4'd5;
      CMD_IO_WRITE:  return 4'd5;
      default:       return 4'd0;
    endcase
  endfunction

endpackage

// File: rtl/cbcs_if.sv
interface cbcs_in_if import cbcs_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface cbcs_out_if import cbcs_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/cbcs_step.sv
module cbcs_step import cbcs_pkg::*; (
  input  seq_state_t st,
  input  in_item_t   item,
  output seq_state_t st_next,
  output out_item_t  res
);

  cmd_t       cmd;
  cmd_t       a;
  logic [3:0] k;
  logic       busy;
  logic       done;

  assign cmd = cmd_t'(item.cmd);
  assign a   = st.active_cmd;
  assign k   = st.t_step;

  // one half tick of the bus sequencer
  always_comb begin
    st_next = st;
    busy    = 1'b0;
    done    = 1'b0;
    if (st.t_step == 4'd0) begin
      // start a cycle only on a rising tick
      if (!st.half_phase && cmd != CMD_NONE) begin
        busy              = 1'b1;
        st_next.active_cmd = cmd;
        st_next.t_step     = 4'd1;
        if (cmd != CMD_HALT_FETCH) st_next.addr_hold = item.address;
        case (cmd)
          CMD_FETCH: begin
            st_next.strobe_bits[S_M1] = 1'b0;
          end
          CMD_INT_ACK: begin
            st_next.strobe_bits[S_MREQ] = 1'b1;
            st_next.strobe_bits[S_RD]   = 1'b1;
            st_next.strobe_bits[S_M1]   = 1'b0;
          end
          CMD_MEM_WRITE: begin
            st_next.data_hold = item.write_data;
          end
          CMD_IO_WRITE: begin
            st_next.data_hold  = item.write_data;
            st_next.drive_flag = 1'b1;
          end
          default: begin
          end
        endcase
      end
    end else begin
      busy = 1'b1;
      if (k == check_step(a) && !item.wait_line) begin
        // wait state: step back so that the check is repeated
        st_next.t_step = k - 4'd1;
      end else begin
        case (a)
          CMD_FETCH, CMD_HALT_FETCH: begin
            if (k == 4'd1) begin
              if (a == CMD_FETCH) begin
                st_next.strobe_bits[S_MREQ] = 1'b0;
                st_next.strobe_bits[S_RD]   = 1'b0;
              end else begin
                st_next.captured_byte = BYTE_ZERO;
              end
            end else if (k == 4'd4) begin
              if (a == CMD_FETCH) st_next.captured_byte = item.bus_data_in;
              st_next.addr_hold = {item.refresh_page, st.refresh_count};
              st_next.strobe_bits[S_MREQ] = 1'b1;
              st_next.strobe_bits[S_RD]   = 1'b1;
              st_next.strobe_bits[S_M1]   = 1'b1;
              st_next.strobe_bits[S_RFSH] = 1'b0;
            end else if (k == 4'd5) begin
              st_next.strobe_bits[S_MREQ] = 1'b0;
            end else if (k == 4'd7) begin
              st_next.strobe_bits[S_MREQ] = 1'b1;
              st_next.strobe_bits[S_RFSH] = 1'b1;
              st_next.refresh_count = (st.refresh_count & RFSH_KEEP_MSK) |
                                      ((st.refresh_count + 8'd1) & RFSH_WRAP_MSK);
            end
          end
          CMD_INT_ACK: begin
            if (k == 4'd5) begin
              st_next.strobe_bits[S_IORQ] = 1'b0;
            end else if (k == 4'd8) begin
              st_next.captured_byte = item.bus_data_in;
              st_next.addr_hold = {item.refresh_page, st.refresh_count};
              st_next.strobe_bits[S_IORQ] = 1'b1;
              st_next.strobe_bits[S_RD]   = 1'b1;
              st_next.strobe_bits[S_M1]   = 1'b1;
              st_next.strobe_bits[S_RFSH] = 1'b0;
            end else if (k == 4'd9) begin
              st_next.strobe_bits[S_MREQ] = 1'b0;
            end else if (k == 4'd11) begin
              st_next.strobe_bits[S_MREQ] = 1'b1;
              st_next.strobe_bits[S_RFSH] = 1'b1;
              st_next.refresh_count = (st.refresh_count & RFSH_KEEP_MSK) |
                                      ((st.refresh_count + 8'd1) & RFSH_WRAP_MSK);
            end
          end
          CMD_MEM_READ: begin
            if (k == 4'd1) begin
              st_next.strobe_bits[S_MREQ] = 1'b0;
              st_next.strobe_bits[S_RD]   = 1'b0;
            end else if (k == 4'd4) begin
              st_next.captured_byte = item.bus_data_in;
            end else if (k == 4'd5) begin
              st_next.strobe_bits[S_MREQ] = 1'b1;
              st_next.strobe_bits[S_RD]   = 1'b1;
            end
          end
          CMD_MEM_WRITE: begin
            if (k == 4'd1) begin
              st_next.drive_flag = 1'b1;
              st_next.strobe_bits[S_MREQ] = 1'b0;
            end else if (k == 4'd3) begin
              st_next.strobe_bits[S_WR] = 1'b0;
            end else if (k == 4'd5) begin
              st_next.strobe_bits[S_MREQ] = 1'b1;
              st_next.strobe_bits[S_WR]   = 1'b1;
              st_next.drive_flag = 1'b0;
            end
          end
          CMD_IO_READ: begin
            if (k == 4'd2) begin
              st_next.strobe_bits[S_IORQ] = 1'b0;
              st_next.strobe_bits[S_RD]   = 1'b0;
            end else if (k == 4'd6) begin
              st_next.captured_byte = item.bus_data_in;
            end else if (k == 4'd7) begin
              st_next.strobe_bits[S_IORQ] = 1'b1;
              st_next.strobe_bits[S_RD]   = 1'b1;
            end
          end
          default: begin
            // io write
            if (k == 4'd2) begin
              st_next.strobe_bits[S_IORQ] = 1'b0;
              st_next.strobe_bits[S_WR]   = 1'b0;
            end else if (k == 4'd7) begin
              st_next.strobe_bits[S_IORQ] = 1'b1;
              st_next.strobe_bits[S_WR]   = 1'b1;
              st_next.drive_flag = 1'b0;
            end
          end
        endcase
        // advance or finish the machine cycle
        if (k >= last_step(a)) begin
          done               = 1'b1;
          st_next.t_step     = 4'd0;
          st_next.active_cmd = CMD_NONE;
        end else begin
          st_next.t_step = k + 4'd1;
        end
      end
    end
    st_next.half_phase = ~st.half_phase;
  end

  // pins as they stand after this half tick
  always_comb begin
    res.addr_out   = st_next.addr_hold;
    res.data_out   = st_next.drive_flag ? st_next.data_hold : BYTE_ZERO;
    res.data_drive = st_next.drive_flag;
    res.mreq_line  = st_next.strobe_bits[S_MREQ];
    res.rd_line    = st_next.strobe_bits[S_RD];
    res.wr_line    = st_next.strobe_bits[S_WR];
    res.iorq_line  = st_next.strobe_bits[S_IORQ];
    res.m1_line    = st_next.strobe_bits[S_M1];
    res.rfsh_line  = st_next.strobe_bits[S_RFSH];
    res.read_byte  = st_next.captured_byte;
    res.cycle_done = done;
    res.busy_res   = busy;
  end

endmodule

// File: rtl/cpu_bus_cycle_sequencer_core.sv
// Bus machine-cycle sequencer. Each request on item is one half clock of the
// CPU bus (rising, falling, alternating from reset) and yields exactly one
// request on result with the address, data and active-low strobe levels for
// that half tick, plus the captured read byte and cycle status. A request is
// taken every clock cycle: the input is held in an input register, the step
// logic updates the sequencer state and loads the result register, so a result
// passes through the input and result registers in turn; the result register
// stalls the input side only while a result is waiting and result.ready is low.
// Commands start only while idle on a rising half tick; WAIT low on the
// check tick stretches the cycle by whole clocks.
module cpu_bus_cycle_sequencer_core import cbcs_pkg::*; (
  input logic        clk,
  input logic        rst,
  cbcs_in_if.sink    item,
  cbcs_out_if.source result
);

  logic       in_valid;
  in_item_t   in_item;
  logic       advance;
  seq_state_t st;
  seq_state_t st_next;
  logic       out_valid;
  out_item_t  out_item;
  out_item_t  res_next;

  assign advance     = in_valid && (!out_valid || result.ready);
  assign item.ready  = !in_valid || advance;
  assign result.valid   = out_valid;
  assign result.payload = out_item;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item.ready) begin
      in_valid <= item.valid;
    end
    if (item.ready && item.valid) in_item <= item.payload;
  end

  cbcs_step u_step (
    .st      (st),
    .item    (in_item),
    .st_next (st_next),
    .res     (res_next)
  );

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      st.half_phase    <= 1'b0;
      st.t_step        <= 4'd0;
      st.active_cmd    <= CMD_NONE;
      st.addr_hold     <= 16'd0;
      st.data_hold     <= BYTE_ZERO;
      st.drive_flag    <= 1'b0;
      st.strobe_bits   <= ALL_STROBES;
      st.captured_byte <= BYTE_ZERO;
      st.refresh_count <= BYTE_ZERO;
    end else if (advance) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
    if (advance) out_item <= res_next;
  end

  // idle bus has every strobe released and the data bus floated
  assert property (@(posedge clk) disable iff (rst)
    (st.t_step == 4'd0) |-> (st.strobe_bits == ALL_STROBES && !st.drive_flag))
    else $error("strobes or data drive left active while idle");

  // no command runs past its final half tick
  assert property (@(posedge clk) disable iff (rst)
    (st.t_step != 4'd0) |-> (st.t_step <= last_step(st.active_cmd) &&
                             st.active_cmd != CMD_NONE))
    else $error("half tick index out of range for active command");

  // every processed request flips the phase
  assert property (@(posedge clk) disable iff (rst)
    (!rst && advance) |=> (st.half_phase != $past(st.half_phase)))
    else $error("half phase did not alternate");

  // refresh counter keeps its top bit
  assert property (@(posedge clk) disable iff (rst)
    (!rst && advance) |=> $stable(st.refresh_count[7]))
    else $error("refresh counter top bit changed");

  // a finished cycle is always reported as busy
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.cycle_done) |-> out_item.busy_res)
    else $error("cycle end reported without busy");

endmodule
